// ===== sv/int64_to_decimal_ascii_unit_assert.svh =====
// Assertion macros for the decimal text converter RTL.
// Depends on nothing; included by i2dec_back, the module that carries assertions.
`ifndef INT64_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH
`define INT64_TO_DECIMAL_ASCII_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF

// Condition must hold at every edge outside reset.
`define I2DEC_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define I2DEC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define I2DEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define I2DEC_ASSERT_ALWAYS(lbl, clk, rstn, cond, msg)
`define I2DEC_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons, msg)
`define I2DEC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== sv/i2dec_pkg.sv =====
// Shared types, constants and the double-dabble step for the decimal text converter.
// No dependencies.
package i2dec_pkg;

  localparam int unsigned VAL_W         = 64;
  localparam int unsigned DIGITS        = 20;
  localparam int unsigned BCD_W         = 4 * DIGITS;
  localparam int unsigned BITS_PER_STEP = 4;
  localparam int unsigned CONV_STEPS    = VAL_W / BITS_PER_STEP;
  localparam int unsigned STEP_W        = $clog2(CONV_STEPS);
  localparam int unsigned IDX_W         = $clog2(DIGITS);
  localparam int unsigned CHAR_W        = 8;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  // One classified item: magnitude and sign flag.
  typedef struct packed {
    logic [VAL_W-1:0] mag;
    logic             neg;
  } item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEAD,
    ST_SIGN,
    ST_EMIT
  } back_state_t;

  // One shift-add-3 step: add 3 to every BCD digit of 5 or more, then shift in one binary bit.
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic             b);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int i = 0; i < DIGITS; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], b};
  endfunction

endpackage

// ===== sv/i2dec_front.sv =====
// Front end: accepts input transactions and classifies sign and magnitude.
// Depends on i2dec_pkg.
module i2dec_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [i2dec_pkg::VAL_W-1:0]         in_tdata,   // [63:0] value
  input  logic                                in_tuser,   // [0] is_signed
  output logic                                push_valid,
  input  logic                                push_ready,
  output i2dec_pkg::item_t                    push_data
);

  logic             valid_r, valid_nxt;
  i2dec_pkg::item_t item_r, item_nxt;
  logic             accept;
  logic             neg;

  // The stage takes a new transaction when empty or when its item moves on.
  assign in_tready = !valid_r || push_ready;
  assign accept    = in_tvalid && in_tready;
  assign neg       = in_tuser && in_tdata[i2dec_pkg::VAL_W-1];

  always_comb begin
    item_nxt  = item_r;
    valid_nxt = valid_r;
    if (accept) begin
      item_nxt.neg = neg;
      item_nxt.mag = neg ? (~in_tdata + 64'd1) : in_tdata;
      valid_nxt    = 1'b1;
    end else if (push_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign push_valid = valid_r;
  assign push_data  = item_r;

endmodule

// ===== sv/i2dec_fifo.sv =====
// Short queue of classified items between the front end and the converter.
// Depends on i2dec_pkg.
module i2dec_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  i2dec_pkg::item_t push_data,
  output logic             pop_valid,
  input  logic             pop,
  output i2dec_pkg::item_t pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  i2dec_pkg::item_t  slot_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = slot_r[rd_ptr_r];

  // Pointer and occupancy update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ===== sv/i2dec_back.sv =====
// Back end: double-dabble conversion, leading digit search and character output.
// Depends on i2dec_pkg and int64_to_decimal_ascii_unit_assert.svh.
`include "int64_to_decimal_ascii_unit_assert.svh"

module i2dec_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  i2dec_pkg::item_t              q_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [i2dec_pkg::CHAR_W-1:0]  out_tdata,  // [7:0] text_char
  output logic                          out_tlast   // last
);

  i2dec_pkg::back_state_t             state_r, state_nxt;
  logic [i2dec_pkg::VAL_W-1:0]        bin_r, bin_nxt;
  logic [i2dec_pkg::BCD_W-1:0]        bcd_r, bcd_nxt;
  logic [i2dec_pkg::STEP_W-1:0]       step_r, step_nxt;
  logic [i2dec_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic                               neg_r, neg_nxt;
  logic                               out_tvalid_r, out_tvalid_nxt;
  logic [i2dec_pkg::CHAR_W-1:0]       out_tdata_r, out_tdata_nxt;
  logic                               out_tlast_r, out_tlast_nxt;
  logic                               slot_free;
  logic [3:0]                         cur_digit;
  logic [i2dec_pkg::BCD_W-1:0]        bcd_step [i2dec_pkg::BITS_PER_STEP + 1];
  logic [i2dec_pkg::IDX_W-1:0]        lead_idx;

  assign slot_free = !out_tvalid_r || out_tready;
  assign cur_digit = bcd_r[{idx_r, 2'b00} +: 4];

  // Four dabble steps per cycle, most significant remaining bits first.
  always_comb begin
    bcd_step[0] = bcd_r;
    for (int i = 0; i < i2dec_pkg::BITS_PER_STEP; i++) begin
      bcd_step[i+1] = i2dec_pkg::dabble_step(bcd_step[i],
                                             bin_r[i2dec_pkg::VAL_W-1-i]);
    end
  end

  // Highest nonzero digit; zero keeps digit 0.
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < i2dec_pkg::DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        lead_idx = i2dec_pkg::IDX_W'(i);
      end
    end
  end

  // Sequencer next state and output register load.
  always_comb begin
    state_nxt      = state_r;
    bin_nxt        = bin_r;
    bcd_nxt        = bcd_r;
    step_nxt       = step_r;
    idx_nxt        = idx_r;
    neg_nxt        = neg_r;
    q_pop          = 1'b0;
    out_tvalid_nxt = out_tready ? 1'b0 : out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    out_tlast_nxt  = out_tlast_r;
    case (state_r)
      i2dec_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          bin_nxt   = q_data.mag;
          neg_nxt   = q_data.neg;
          bcd_nxt   = '0;
          step_nxt  = '0;
          state_nxt = i2dec_pkg::ST_CONV;
        end
      end
      i2dec_pkg::ST_CONV: begin
        bcd_nxt  = bcd_step[i2dec_pkg::BITS_PER_STEP];
        bin_nxt  = bin_r << i2dec_pkg::BITS_PER_STEP;
        step_nxt = step_r + 1'b1;
        if (step_r == i2dec_pkg::STEP_W'(i2dec_pkg::CONV_STEPS - 1)) begin
          state_nxt = i2dec_pkg::ST_LEAD;
        end
      end
      i2dec_pkg::ST_LEAD: begin
        idx_nxt   = lead_idx;
        state_nxt = neg_r ? i2dec_pkg::ST_SIGN : i2dec_pkg::ST_EMIT;
      end
      i2dec_pkg::ST_SIGN: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = i2dec_pkg::CHAR_MINUS;
          out_tlast_nxt  = 1'b0;
          state_nxt      = i2dec_pkg::ST_EMIT;
        end
      end
      i2dec_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_tvalid_nxt = 1'b1;
          out_tdata_nxt  = i2dec_pkg::CHAR_ZERO + {4'd0, cur_digit};
          out_tlast_nxt  = (idx_r == '0);
          if (idx_r == '0) begin
            state_nxt = i2dec_pkg::ST_IDLE;
          end else begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: begin
        state_nxt = i2dec_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= i2dec_pkg::ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r       <= bin_nxt;
    bcd_r       <= bcd_nxt;
    step_r      <= step_nxt;
    idx_r       <= idx_nxt;
    neg_r       <= neg_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tlast_r <= out_tlast_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  // The digit index never points past the top digit while emitting.
  `I2DEC_ASSERT_IMPLIES(a_idx_range, clk, rst_n, state_r == i2dec_pkg::ST_EMIT, idx_r <= i2dec_pkg::IDX_W'(i2dec_pkg::DIGITS - 1), "digit index out of range")
  // The final character of a number is always a digit.
  `I2DEC_ASSERT_IMPLIES(a_last_digit, clk, rst_n, out_tvalid_r && out_tlast_r, out_tdata_r >= i2dec_pkg::CHAR_ZERO && out_tdata_r <= i2dec_pkg::CHAR_NINE, "last character is not a digit")
  // The conversion loop ends after its fixed number of steps.
  `I2DEC_ASSERT_NEXT(a_conv_done, clk, rst_n, state_r == i2dec_pkg::ST_CONV && step_r == i2dec_pkg::STEP_W'(i2dec_pkg::CONV_STEPS - 1), state_r == i2dec_pkg::ST_LEAD, "conversion did not finish")
  // A minus sign is only produced for negative values.
  `I2DEC_ASSERT_IMPLIES(a_sign_neg, clk, rst_n, state_r == i2dec_pkg::ST_SIGN, neg_r, "sign state for a non-negative value")

endmodule

// ===== sv/int64_to_decimal_ascii_unit.sv =====
// 64-bit binary to decimal ASCII text converter, one character per output transaction.
// Each number passes the front-end register and the queue, then the double-dabble
// loop, the leading digit search and the output register, one character per cycle
// unless out_tready stalls; a further number starts once the last character is loaded.
// Reset: rst_n is synchronous and active low; it empties the queue and output register.
// Depends on i2dec_pkg, i2dec_front, i2dec_fifo and i2dec_back.
module int64_to_decimal_ascii_unit #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [i2dec_pkg::VAL_W-1:0]          in_tdata,   // [63:0] value
  input  logic                                 in_tuser,   // [0] is_signed
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [i2dec_pkg::CHAR_W-1:0]         out_tdata,  // [7:0] text_char
  output logic                                 out_tlast   // last
);

  logic             push_valid, push_ready;
  i2dec_pkg::item_t push_data;
  logic             q_valid, q_pop;
  i2dec_pkg::item_t q_data;

  // Classification of incoming transactions.
  i2dec_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // Decoupling queue.
  i2dec_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_data   (q_data)
  );

  // Conversion and character output.
  i2dec_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_data     (q_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
